### rtl/core/kdef_pkg.sv
// shared types, constants and helpers for the key debounce event fifo
package kdef_pkg;

  localparam int NUM_KEYS             = 4;
  localparam int NUM_SLOTS            = 2 * NUM_KEYS;
  localparam int FILTER_TIME_DEF      = 5;
  localparam int FIFO_DEPTH_DEF       = 16;
  localparam logic [NUM_KEYS-1:0] ACTIVE_HIGH_MASK_DEF = 4'b0001;

  localparam int CODE_W  = 4;
  localparam int LONG_W  = 16;
  localparam int REP_W   = 8;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [LONG_W-1:0] LONG_TIME_RST = 16'd100;
  localparam logic [REP_W-1:0]  REP_RST       = 8'd0;

  // register groups, selected by the top bit of the register index
  localparam logic REG_GRP_LONG   = 1'b0;
  localparam logic REG_GRP_REPEAT = 1'b1;

  // event code offsets within one key's group of three
  localparam int CODE_PRESS_OFS   = 1;
  localparam int CODE_RELEASE_OFS = 2;
  localparam int CODE_LONG_OFS    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LONG_W-1:0] long_time;
    logic [REP_W-1:0]  rep_cfg;
    logic              clr_repeat;
  } key_cfg_t;

  typedef struct packed {
    logic              put_a;
    logic [CODE_W-1:0] code_a;
    logic              put_b;
    logic [CODE_W-1:0] code_b;
  } key_evt_t;

  function automatic logic [CODE_W-1:0] key_code(input int key, input int ofs);
    return CODE_W'(3 * key + ofs);
  endfunction

endpackage

### rtl/core/kdef_cfg.sv
// configuration registers behind the apb-style port
module kdef_cfg
  import kdef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output key_cfg_t              key_cfg [NUM_KEYS]
);

  logic [LONG_W-1:0] long_time [NUM_KEYS];
  logic [REP_W-1:0]  rep_cfg   [NUM_KEYS];
  logic              wr;
  logic              grp;
  logic [1:0]        key_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign grp     = paddr[4];
  assign key_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        long_time[k] <= LONG_TIME_RST;
        rep_cfg[k]   <= REP_RST;
      end
    end else if (wr) begin
      if (grp == REG_GRP_LONG) begin
        long_time[key_sel] <= pwdata[LONG_W-1:0];
      end else begin
        rep_cfg[key_sel] <= pwdata[REP_W-1:0];
      end
    end
  end

  always_comb begin
    if (grp == REG_GRP_LONG) begin
      prdata = DATA_W'(long_time[key_sel]);
    end else begin
      prdata = DATA_W'(rep_cfg[key_sel]);
    end
  end

  // a write to either register of a key restarts its repeat count
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_cfg[k].long_time  = long_time[k];
      key_cfg[k].rep_cfg    = rep_cfg[k];
      key_cfg[k].clr_repeat = wr && (key_sel == 2'(k));
    end
  end

endmodule

### rtl/core/kdef_key.sv
// debounce filter, press state and long press / repeat timing for one key
module kdef_key
  import kdef_pkg::*;
#(
  parameter int FILTER_TIME = FILTER_TIME_DEF,
  parameter int KEY_INDEX   = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     scan_en,
  input  logic     down,
  input  key_cfg_t cfg,
  output logic     pressed_next,
  output key_evt_t evt
);

  localparam int FC_W = $clog2(2 * FILTER_TIME + 1);
  localparam logic [FC_W-1:0] FC_MID = FC_W'(FILTER_TIME);
  localparam logic [FC_W-1:0] FC_TOP = FC_W'(2 * FILTER_TIME);
  localparam logic [FC_W-1:0] FC_RST = FC_W'(FILTER_TIME / 2);

  logic [FC_W-1:0]   filter_count, filter_count_next;
  logic              pressed, pressed_upd;
  logic [LONG_W-1:0] long_count, long_count_next, long_inc;
  logic [REP_W-1:0]  repeat_count, repeat_count_next, rep_inc;
  key_evt_t          evt_raw;

  assign long_inc = long_count + 1'b1;
  assign rep_inc  = repeat_count + 1'b1;

  always_comb begin
    filter_count_next = filter_count;
    pressed_upd       = pressed;
    long_count_next   = long_count;
    repeat_count_next = repeat_count;
    evt_raw           = '0;
    if (down) begin
      if (filter_count < FC_MID) begin
        filter_count_next = FC_MID;
      end else if (filter_count < FC_TOP) begin
        filter_count_next = filter_count + 1'b1;
      end else begin
        if (!pressed) begin
          pressed_upd    = 1'b1;
          evt_raw.put_a  = 1'b1;
          evt_raw.code_a = key_code(KEY_INDEX, CODE_PRESS_OFS);
        end
        if ((cfg.long_time != '0) && (long_count < cfg.long_time)) begin
          long_count_next = long_inc;
          if (long_inc == cfg.long_time) begin
            if (cfg.rep_cfg != '0) begin
              // repeat mode: restart the long period, count periods
              long_count_next = '0;
              if (rep_inc >= cfg.rep_cfg) begin
                repeat_count_next = '0;
                evt_raw.put_b     = 1'b1;
                evt_raw.code_b    = key_code(KEY_INDEX, CODE_PRESS_OFS);
              end else begin
                repeat_count_next = rep_inc;
              end
            end else begin
              evt_raw.put_b  = 1'b1;
              evt_raw.code_b = key_code(KEY_INDEX, CODE_LONG_OFS);
            end
          end
        end
      end
    end else begin
      if (filter_count > FC_MID) begin
        filter_count_next = FC_MID;
      end else if (filter_count != '0) begin
        filter_count_next = filter_count - 1'b1;
      end else if (pressed) begin
        pressed_upd    = 1'b0;
        evt_raw.put_a  = 1'b1;
        evt_raw.code_a = key_code(KEY_INDEX, CODE_RELEASE_OFS);
      end
      long_count_next   = '0;
      repeat_count_next = '0;
    end
  end

  assign pressed_next = scan_en ? pressed_upd : pressed;
  assign evt          = scan_en ? evt_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count <= FC_RST;
      pressed      <= 1'b0;
      long_count   <= '0;
      repeat_count <= '0;
    end else begin
      if (scan_en) begin
        filter_count <= filter_count_next;
        pressed      <= pressed_upd;
        long_count   <= long_count_next;
        repeat_count <= repeat_count_next;
      end
      if (cfg.clr_repeat) begin
        repeat_count <= '0;
      end
    end
  end

endmodule

### rtl/core/kdef_fifo.sv
// event ring buffer taking up to two codes per key on a scan tick
module kdef_fifo
  import kdef_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [KIND_W-1:0] kind,
  input  key_evt_t          evt [NUM_KEYS],
  output logic [CODE_W-1:0] read_code
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [CODE_W-1:0] store [FIFO_DEPTH];
  logic [PTR_W-1:0]  read_ptr, write_ptr;
  logic [PTR_W-1:0]  slot_addr [NUM_SLOTS+1];
  logic              slot_put  [NUM_SLOTS];
  logic [CODE_W-1:0] slot_code [NUM_SLOTS];
  logic              do_scan, do_read, do_clear, empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign do_scan  = en && (kind == KIND_SCAN);
  assign do_read  = en && (kind == KIND_READ);
  assign do_clear = en && (kind == KIND_CLEAR);
  assign empty    = (read_ptr == write_ptr);

  // slots in key order, each key's first code ahead of its second
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      slot_put[2*k]    = evt[k].put_a;
      slot_code[2*k]   = evt[k].code_a;
      slot_put[2*k+1]  = evt[k].put_b;
      slot_code[2*k+1] = evt[k].code_b;
    end
    slot_addr[0] = write_ptr;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_addr[s+1] = slot_put[s] ? ptr_inc(slot_addr[s]) : slot_addr[s];
    end
  end

  // later slots win if the ring wraps onto itself within one tick
  always_ff @(posedge clk) begin
    if (do_scan) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (slot_put[s]) begin
          store[slot_addr[s]] <= slot_code[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      write_ptr <= '0;
    end else begin
      if (do_scan) begin
        write_ptr <= slot_addr[NUM_SLOTS];
      end
      if (do_read && !empty) begin
        read_ptr <= ptr_inc(read_ptr);
      end
      if (do_clear) begin
        read_ptr <= write_ptr;
      end
    end
  end

  assign read_code = (do_read && !empty) ? store[read_ptr] : '0;

endmodule

### rtl/core/key_debounce_event_fifo_top.sv
// top level of the key debounce event fifo
// Debounces four buttons and queues their press, release and long press codes in a
// ring buffer. Every request carries a kind: a scan tick samples key_levels, a read
// pops one code (0 when the queue is empty), a clear empties the queue; kind 3 does
// nothing. Each request produces exactly one result with event_code and the debounced
// pressed_mask after the request. A request is registered on entry, processed by one
// pass of per-key counters and the fifo write logic, and its result lands in an output
// register. One request is taken every cycle as long as the output side keeps up, since
// every key and the fifo pointers update in that one pass. The queue has no overflow
// guard: more than FIFO_DEPTH-1 unread codes wrap and the older ones are lost. Codes are
// 3k+1 press (also the repeat code), 3k+2 release, 3k+3 long press. Registers:
// long_time_key0..3 at 0x00..0x0c, repeat_key0..3 at 0x10..0x1c; writing either
// register of a key restarts its repeat count. Write the registers only while no
// request is in flight.
module key_debounce_event_fifo_top
  import kdef_pkg::*;
#(
  parameter int                  FILTER_TIME      = FILTER_TIME_DEF,
  parameter int                  FIFO_DEPTH       = FIFO_DEPTH_DEF,
  parameter logic [NUM_KEYS-1:0] ACTIVE_HIGH_MASK = ACTIVE_HIGH_MASK_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [NUM_KEYS-1:0] key_levels,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   event_code,
  output logic [NUM_KEYS-1:0] pressed_mask,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // input register
  logic                s1_valid;
  logic [KIND_W-1:0]   s1_kind;
  logic [NUM_KEYS-1:0] s1_levels;

  logic                out_busy;  // output register holds a result not yet taken
  logic                fire;      // request in the input register is processed now
  logic                scan_en;
  logic [NUM_KEYS-1:0] pressed_next;
  logic [CODE_W-1:0]   read_code;
  key_cfg_t            key_cfg [NUM_KEYS];
  key_evt_t            key_evt [NUM_KEYS];

  assign out_busy = out_valid && out_stall;
  assign fire     = s1_valid && !out_busy;
  assign in_stall = s1_valid && out_busy;
  assign scan_en  = fire && (s1_kind == KIND_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload only loads on an accepted request
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind   <= kind;
      s1_levels <= key_levels;
    end
  end

  kdef_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_cfg (key_cfg)
  );

  // one debouncer per key, down level follows the polarity mask
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdef_key #(
      .FILTER_TIME (FILTER_TIME),
      .KEY_INDEX   (k)
    ) u_key (
      .clk          (clk),
      .rst          (rst),
      .scan_en      (scan_en),
      .down         (ACTIVE_HIGH_MASK[k] ? s1_levels[k] : !s1_levels[k]),
      .cfg          (key_cfg[k]),
      .pressed_next (pressed_next[k]),
      .evt          (key_evt[k])
    );
  end

  kdef_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .kind      (s1_kind),
    .evt       (key_evt),
    .read_code (read_code)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_busy) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_code   <= read_code;
      pressed_mask <= pressed_next;
    end
  end

  // a stall back to the request side only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("request stall without a stalled result");

  // a processed request always shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

  // a stalled result holds the request behind it in the input register
  a_no_fire_when_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && s1_valid) |=> s1_valid)
    else $error("held request lost while result stalled");

endmodule
